>>> hdl/scts_pkg.sv
// Shared types, codes and character constants for the string content token scanner.
package scts_pkg;

    // Default sizing for the top-level parameters.
    localparam int unsigned COUNT_BITS_DEF = 16;
    localparam int unsigned MAX_POUNDS_DEF = 6;

    // Fixed field widths of the request and result channels.
    localparam int unsigned VK_W   = 17;
    localparam int unsigned CP_W   = 21;
    localparam int unsigned KIND_W = 5;
    localparam int unsigned LEN_W  = 16;

    // Code points that steer the scan.
    localparam logic [CP_W-1:0] CH_EOF    = 21'h000000;
    localparam logic [CP_W-1:0] CH_TAB    = 21'h000009;
    localparam logic [CP_W-1:0] CH_NL     = 21'h00000A;
    localparam logic [CP_W-1:0] CH_FF     = 21'h00000C;
    localparam logic [CP_W-1:0] CH_CR     = 21'h00000D;
    localparam logic [CP_W-1:0] CH_SPACE  = 21'h000020;
    localparam logic [CP_W-1:0] CH_QUOTE  = 21'h000022;
    localparam logic [CP_W-1:0] CH_POUND  = 21'h000023;
    localparam logic [CP_W-1:0] CH_LPAREN = 21'h000028;
    localparam logic [CP_W-1:0] CH_MINUS  = 21'h00002D;
    localparam logic [CP_W-1:0] CH_GT     = 21'h00003E;
    localparam logic [CP_W-1:0] CH_LBRACK = 21'h00005B;
    localparam logic [CP_W-1:0] CH_BSLASH = 21'h00005C;

    // What the running scan looks for.
    typedef enum logic [2:0] {
        MODE_NONE,
        MODE_SL,
        MODE_ML,
        MODE_SLX,
        MODE_MLX,
        MODE_SYM
    } t_mode;

    // Where inside the token the scan stands.
    typedef enum logic [1:0] {
        PH_CONTENT,
        PH_QUOTES,
        PH_POUNDS,
        PH_MINUS
    } t_phase;

    // Control part of the scan state; the counters travel separately.
    typedef struct packed {
        logic        busy;
        t_mode       mode;
        logic [2:0]  target;
        t_phase      phase;
        logic        content_seen;
        logic        mark_set;
        logic [2:0]  pound_progress;
        logic [1:0]  quote_run;
        logic [2:0]  sym_en;
    } t_ctrl;

    // Scan selection made from the valid-kinds set of a begin request.
    typedef struct packed {
        t_mode       mode;
        logic [2:0]  target;
        logic [2:0]  sym_en;
    } t_decode;

    // One result as it leaves the block.
    typedef struct packed {
        logic              accepted;
        logic [KIND_W-1:0] kind;
        logic [LEN_W-1:0]  length;
        logic [LEN_W-1:0]  blanks;
    } t_result;

endpackage

>>> hdl/scts_kind_decode.sv
// Priority selection of the scan mode from the valid-kinds set.
module scts_kind_decode #(
    parameter int unsigned MAX_POUNDS = scts_pkg::MAX_POUNDS_DEF
) (
    input  logic [scts_pkg::VK_W-1:0] i_valid_kinds,
    output scts_pkg::t_decode         o_dec
);
    import scts_pkg::*;

    localparam int unsigned ML_BASE   = MAX_POUNDS + 1;
    localparam int unsigned SYM_BASE  = 2 * MAX_POUNDS + 2;
    localparam int unsigned NUM_KINDS = SYM_BASE + 3;
    localparam int unsigned KX_W      = (NUM_KINDS > VK_W) ? NUM_KINDS : VK_W;

    logic [KX_W-1:0] w_kinds;
    logic            w_all_set;

    // Kind bits above the field read as zero.
    assign w_kinds   = KX_W'(i_valid_kinds);
    assign w_all_set = &w_kinds[NUM_KINDS-1:0];

    // None if all are set, else plain single-line, plain multiline, pound counts, symbols.
    always_comb begin
        o_dec = '0;
        o_dec.mode = MODE_NONE;
        if (w_all_set) begin
            o_dec.mode = MODE_NONE;
        end else if (w_kinds[0]) begin
            o_dec.mode = MODE_SL;
        end else if (w_kinds[ML_BASE]) begin
            o_dec.mode = MODE_ML;
        end else begin
            for (int n = 1; n <= int'(MAX_POUNDS); n++) begin
                if (o_dec.mode == MODE_NONE) begin
                    if (w_kinds[n]) begin
                        o_dec.mode   = MODE_SLX;
                        o_dec.target = 3'(n);
                    end else if (w_kinds[ML_BASE + n]) begin
                        o_dec.mode   = MODE_MLX;
                        o_dec.target = 3'(n);
                    end
                end
            end
            if (o_dec.mode == MODE_NONE && w_kinds[SYM_BASE +: 3] != 3'd0) begin
                o_dec.mode   = MODE_SYM;
                o_dec.sym_en = w_kinds[SYM_BASE +: 3];
            end
        end
    end

endmodule

>>> hdl/scts_step.sv
// Next scan state and result for one code point.
module scts_step #(
    parameter int unsigned COUNT_BITS = scts_pkg::COUNT_BITS_DEF,
    parameter int unsigned MAX_POUNDS = scts_pkg::MAX_POUNDS_DEF
) (
    input  logic                      i_begin,
    input  logic [scts_pkg::CP_W-1:0] i_code_point,
    input  scts_pkg::t_decode         i_dec,
    input  scts_pkg::t_ctrl           i_ctrl,
    input  logic [COUNT_BITS-1:0]     i_adv,
    input  logic [COUNT_BITS-1:0]     i_mark,
    input  logic [COUNT_BITS-1:0]     i_blank,
    output scts_pkg::t_ctrl           o_ctrl,
    output logic [COUNT_BITS-1:0]     o_adv,
    output logic [COUNT_BITS-1:0]     o_mark,
    output logic [COUNT_BITS-1:0]     o_blank,
    output logic                      o_fin,
    output scts_pkg::t_result         o_res
);
    import scts_pkg::*;

    localparam int unsigned ML_BASE  = MAX_POUNDS + 1;
    localparam int unsigned SYM_BASE = 2 * MAX_POUNDS + 2;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        sat_inc = (&v) ? v : v + COUNT_BITS'(1);
    endfunction

    function automatic logic [LEN_W-1:0] clip16(input logic [COUNT_BITS-1:0] v);
        logic [31:0] ext;
        ext = 32'(v);
        clip16 = (ext > 32'h0000FFFF) ? 16'hFFFF : ext[LEN_W-1:0];
    endfunction

    t_ctrl                 s;
    logic [COUNT_BITS-1:0] adv;
    logic [COUNT_BITS-1:0] mk;
    logic [COUNT_BITS-1:0] bl;
    logic [COUNT_BITS-1:0] tok;
    logic                  fin;
    logic                  acc;
    logic [KIND_W-1:0]     kind;
    logic [KIND_W-1:0]     str_kind;
    logic [CP_W-1:0]       c;

    always_comb begin
        c    = i_code_point;
        s    = i_ctrl;
        adv  = i_adv;
        mk   = i_mark;
        bl   = i_blank;
        fin  = 1'b0;
        acc  = 1'b0;
        kind = '0;

        // A begin request starts from a clean state with the decoded mode.
        if (i_begin) begin
            s        = '0;
            s.phase  = PH_CONTENT;
            s.mode   = i_dec.mode;
            s.target = i_dec.target;
            s.sym_en = i_dec.sym_en;
            s.busy   = (i_dec.mode != MODE_NONE);
            adv      = '0;
            mk       = '0;
            bl       = '0;
        end

        // Kind reported by a string token in the current mode.
        case (s.mode)
            MODE_ML:  str_kind = KIND_W'(ML_BASE);
            MODE_SLX: str_kind = KIND_W'(s.target);
            MODE_MLX: str_kind = KIND_W'(ML_BASE) + KIND_W'(s.target);
            default:  str_kind = '0;
        endcase

        if (i_begin && i_dec.mode == MODE_NONE) begin
            // Nothing to scan for: reject on the spot.
            fin = 1'b1;
        end else if (s.busy) begin
            if (s.mode == MODE_SL) begin
                // Plain single-line content runs until a terminator.
                if (c inside {CH_QUOTE, CH_BSLASH, CH_NL, CH_CR, CH_EOF}) begin
                    fin  = 1'b1;
                    acc  = s.content_seen;
                    kind = '0;
                end else begin
                    s.content_seen = 1'b1;
                    adv = sat_inc(adv);
                end
            end else if (s.mode == MODE_SYM) begin
                // Adjacent symbol after optional blanks; minus must not open an arrow.
                if (s.phase == PH_MINUS) begin
                    fin = 1'b1;
                    if (c != CH_GT) begin
                        acc  = 1'b1;
                        kind = KIND_W'(SYM_BASE + 2);
                    end
                end else if (c inside {CH_SPACE, CH_TAB, CH_CR, CH_FF}) begin
                    bl = sat_inc(bl);
                end else if (c == CH_LBRACK && s.sym_en[0]) begin
                    adv  = sat_inc(adv);
                    fin  = 1'b1;
                    acc  = 1'b1;
                    kind = KIND_W'(SYM_BASE);
                end else if (c == CH_LPAREN && s.sym_en[1]) begin
                    adv  = sat_inc(adv);
                    fin  = 1'b1;
                    acc  = 1'b1;
                    kind = KIND_W'(SYM_BASE + 1);
                end else if (c == CH_MINUS && s.sym_en[2]) begin
                    adv        = sat_inc(adv);
                    mk         = adv;
                    s.mark_set = 1'b1;
                    s.phase    = PH_MINUS;
                end else begin
                    fin = 1'b1;
                end
            end else begin
                // A quote run that ends falls back to content or moves on to pounds.
                if (s.phase == PH_QUOTES && c != CH_QUOTE) begin
                    if (s.mode == MODE_ML || s.quote_run != 2'd3) begin
                        s.content_seen = 1'b1;
                        s.phase        = PH_CONTENT;
                    end else begin
                        s.phase          = PH_POUNDS;
                        s.pound_progress = '0;
                    end
                end
                // A broken pound run is ordinary content.
                if (s.phase == PH_POUNDS && c != CH_POUND) begin
                    s.content_seen = 1'b1;
                    s.phase        = PH_CONTENT;
                end

                case (s.phase)
                    PH_POUNDS: begin
                        adv = sat_inc(adv);
                        s.pound_progress = s.pound_progress + 3'd1;
                        if (s.pound_progress >= s.target) begin
                            fin  = 1'b1;
                            acc  = s.content_seen;
                            kind = str_kind;
                        end
                    end
                    PH_QUOTES: begin
                        if (s.mode == MODE_ML) begin
                            if (s.quote_run >= 2'd2) begin
                                fin  = 1'b1;
                                acc  = s.content_seen;
                                kind = str_kind;
                            end else begin
                                adv = sat_inc(adv);
                                s.quote_run = s.quote_run + 2'd1;
                            end
                        end else begin
                            adv = sat_inc(adv);
                            if (s.quote_run != 2'd3) begin
                                s.quote_run = s.quote_run + 2'd1;
                            end
                        end
                    end
                    default: begin
                        if (s.mode == MODE_SLX) begin
                            if (c == CH_QUOTE || c == CH_BSLASH) begin
                                mk               = adv;
                                s.mark_set       = 1'b1;
                                adv              = sat_inc(adv);
                                s.phase          = PH_POUNDS;
                                s.pound_progress = '0;
                            end else if (c inside {CH_NL, CH_CR, CH_EOF}) begin
                                mk         = adv;
                                s.mark_set = 1'b1;
                                fin        = 1'b1;
                                acc        = s.content_seen;
                                kind       = str_kind;
                            end else begin
                                s.content_seen = 1'b1;
                                adv = sat_inc(adv);
                            end
                        end else if (c == CH_QUOTE) begin
                            mk          = adv;
                            s.mark_set  = 1'b1;
                            adv         = sat_inc(adv);
                            s.quote_run = 2'd1;
                            s.phase     = PH_QUOTES;
                        end else if (c == CH_BSLASH) begin
                            mk         = adv;
                            s.mark_set = 1'b1;
                            if (s.mode == MODE_ML) begin
                                fin  = 1'b1;
                                acc  = s.content_seen;
                                kind = str_kind;
                            end else begin
                                adv              = sat_inc(adv);
                                s.phase          = PH_POUNDS;
                                s.pound_progress = '0;
                            end
                        end else if (c == CH_EOF) begin
                            mk         = adv;
                            s.mark_set = 1'b1;
                            fin        = 1'b1;
                            acc        = s.content_seen;
                            kind       = str_kind;
                        end else begin
                            s.content_seen = 1'b1;
                            adv = sat_inc(adv);
                        end
                    end
                endcase
            end
        end

        // A decision ends the scan; rejected results carry zero fields.
        if (fin) begin
            s.busy = 1'b0;
        end
        tok = s.mark_set ? mk : adv;
        o_res.accepted = acc;
        o_res.kind     = acc ? kind : '0;
        o_res.length   = acc ? clip16(tok) : '0;
        o_res.blanks   = acc ? clip16(bl) : '0;

        o_ctrl  = s;
        o_adv   = adv;
        o_mark  = mk;
        o_blank = bl;
        o_fin   = fin;
    end

endmodule

>>> hdl/scts_out_queue.sv
// Two-entry result buffer: an output register with a skid entry behind it.
module scts_out_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  scts_pkg::t_result i_data,
    output logic              o_space,
    output logic              o_valid,
    input  logic              i_stall,
    output scts_pkg::t_result o_data
);
    import scts_pkg::*;

    logic    r_head_valid;
    logic    n_head_valid;
    logic    r_skid_valid;
    logic    n_skid_valid;
    t_result r_head;
    t_result n_head;
    t_result r_skid;
    t_result n_skid;
    logic    w_pop;

    assign w_pop   = r_head_valid && !i_stall;
    assign o_space = !r_skid_valid;
    assign o_valid = r_head_valid;
    assign o_data  = r_head;

    // The skid entry moves up first so that order is kept.
    always_comb begin
        n_head_valid = r_head_valid;
        n_skid_valid = r_skid_valid;
        n_head       = r_head;
        n_skid       = r_skid;
        if (w_pop || !r_head_valid) begin
            if (r_skid_valid) begin
                n_head       = r_skid;
                n_head_valid = 1'b1;
                n_skid       = i_data;
                n_skid_valid = i_push;
            end else begin
                n_head       = i_data;
                n_head_valid = i_push;
            end
        end else if (i_push) begin
            n_skid       = i_data;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_head_valid <= n_head_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        r_skid <= n_skid;
    end

endmodule

>>> hdl/string_content_token_scanner_core.sv
// Top level of the string content and adjacent symbol token scanner.
//
//  Channel   Direction  Handshake          Payload
//  request   in         i_valid / o_stall  i_begin_scan, i_valid_kinds, i_code_point
//  result    out        o_valid / i_stall  o_accepted, o_token_kind, o_token_length,
//                                          o_skipped_blanks
//
// One code point is taken every cycle while o_stall is low; a request is registered and
// then stepped through the scan logic when the buffer has room, and any result is buffered.
// The scan state is updated once per request, so the step logic sets the rate.
// Reset clears the scan state, the request register and the result buffer.
// The result side has an output register and a skid entry; o_stall rises only while
// both hold results and a request waits in the input register.
module string_content_token_scanner_core #(
    parameter int unsigned COUNT_BITS = scts_pkg::COUNT_BITS_DEF,
    parameter int unsigned MAX_POUNDS = scts_pkg::MAX_POUNDS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_begin_scan,
    input  logic [scts_pkg::VK_W-1:0]   i_valid_kinds,
    input  logic [scts_pkg::CP_W-1:0]   i_code_point,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_accepted,
    output logic [scts_pkg::KIND_W-1:0] o_token_kind,
    output logic [scts_pkg::LEN_W-1:0]  o_token_length,
    output logic [scts_pkg::LEN_W-1:0]  o_skipped_blanks
);
    import scts_pkg::*;

    localparam int unsigned SYM_BASE = 2 * MAX_POUNDS + 2;

    // Request register.
    logic              r_in_valid;
    logic              n_in_valid;
    logic              r_begin;
    logic [VK_W-1:0]   r_vk;
    logic [CP_W-1:0]   r_cp;

    // Scan state.
    t_ctrl                 r_ctrl;
    t_ctrl                 n_ctrl;
    logic [COUNT_BITS-1:0] r_adv;
    logic [COUNT_BITS-1:0] n_adv;
    logic [COUNT_BITS-1:0] r_mark;
    logic [COUNT_BITS-1:0] n_mark;
    logic [COUNT_BITS-1:0] r_blank;
    logic [COUNT_BITS-1:0] n_blank;

    logic    w_accept;
    logic    w_proceed;
    logic    w_space;
    logic    w_fin;
    t_decode w_dec;
    t_result w_res;
    t_result w_out;

    assign w_proceed = r_in_valid && w_space;
    assign o_stall   = r_in_valid && !w_space;
    assign w_accept  = i_valid && !o_stall;

    // The request register refills in the same cycle it drains.
    always_comb begin
        if (w_accept) begin
            n_in_valid = 1'b1;
        end else if (w_proceed) begin
            n_in_valid = 1'b0;
        end else begin
            n_in_valid = r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_begin <= i_begin_scan;
            r_vk    <= i_valid_kinds;
            r_cp    <= i_code_point;
        end
    end

    scts_kind_decode #(
        .MAX_POUNDS(MAX_POUNDS)
    ) u_decode (
        .i_valid_kinds(r_vk),
        .o_dec        (w_dec)
    );

    scts_step #(
        .COUNT_BITS(COUNT_BITS),
        .MAX_POUNDS(MAX_POUNDS)
    ) u_step (
        .i_begin     (r_begin),
        .i_code_point(r_cp),
        .i_dec       (w_dec),
        .i_ctrl      (r_ctrl),
        .i_adv       (r_adv),
        .i_mark      (r_mark),
        .i_blank     (r_blank),
        .o_ctrl      (n_ctrl),
        .o_adv       (n_adv),
        .o_mark      (n_mark),
        .o_blank     (n_blank),
        .o_fin       (w_fin),
        .o_res       (w_res)
    );

    // Scan state advances once for each request that leaves the request register.
    // An all-zero control word is idle with no mode in the content phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl  <= '0;
            r_adv   <= '0;
            r_mark  <= '0;
            r_blank <= '0;
        end else if (w_proceed) begin
            r_ctrl  <= n_ctrl;
            r_adv   <= n_adv;
            r_mark  <= n_mark;
            r_blank <= n_blank;
        end
    end

    scts_out_queue u_out (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_proceed && w_fin),
        .i_data (w_res),
        .o_space(w_space),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_data (w_out)
    );

    assign o_accepted       = w_out.accepted;
    assign o_token_kind     = w_out.kind;
    assign o_token_length   = w_out.length;
    assign o_skipped_blanks = w_out.blanks;

    // A rejected result carries no kind, length or blanks.
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_accepted) |->
            (o_token_kind == '0 && o_token_length == '0 && o_skipped_blanks == '0))
        else $error("rejected result carries nonzero fields");

    // A string token never reports skipped blanks.
    a_string_no_blanks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_accepted && o_token_kind < KIND_W'(SYM_BASE)) |->
            (o_skipped_blanks == '0))
        else $error("string token reports skipped blanks");

    // A begin request that does not decide at once leaves a scan running.
    a_begin_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proceed && r_begin && !w_fin) |=> (r_ctrl.busy && r_ctrl.mode != MODE_NONE))
        else $error("undecided begin request left no scan running");

    // The closing pound count never runs past its target.
    a_pound_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctrl.pound_progress <= r_ctrl.target)
        else $error("pound progress beyond target");

endmodule
